FILE: rtl/core/bitmap_first_fit_allocator_assert.svh
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define BFFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/bffa_pkg.sv
package bffa_pkg;

	localparam int IDX_W          = 12;
	localparam int VB_W           = 13;
	localparam int VB_RESET       = 4096;
	localparam int MAP_BITS_DEF   = 4096;
	localparam int WORD_BITS_DEF  = 64;
	localparam int TDATA_W        = 16;

	localparam logic MODE_SEARCH = 1'b0;
	localparam logic MODE_WRITE  = 1'b1;

endpackage

FILE: rtl/core/bffa_map_ram.sv
module bffa_map_ram
	import bffa_pkg::*;
#(
	parameter int WORD_COUNT = MAP_BITS_DEF / WORD_BITS_DEF,
	parameter int WORD_BITS  = WORD_BITS_DEF,
	parameter int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic [AW-1:0]        raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [WORD_COUNT];
	logic [WORD_COUNT-1:0] vld_q;
	logic [WORD_BITS-1:0] rdata_q;
	logic                 rvld_q;

	// a word never written reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (32'(raddr) < WORD_COUNT) begin
				rvld_q <= vld_q[raddr];
			end else begin
				rvld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (32'(raddr) < WORD_COUNT) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

FILE: rtl/core/bitmap_first_fit_allocator.sv
// channel  direction  handshake              payload
// s_*      in         s_tvalid / s_tready    tdata {bit_value, bit_index}, tuser mode
// m_*      out        m_tvalid / m_tready    tdata free_index, tuser found
// cfg_*    in         cfg_valid / cfg_ready  cfg_data valid_bits
//
// Search: after the accept, bitmap words are scanned in turn (up to MAP_BITS/WORD_BITS),
//   read through the single read port of the bitmap RAM, and the result is then held
//   until taken; a start at or past the limit skips the scan.
// Write: a read-modify-write of one word, through the RAM's read port and its write port.
// Reset marks every word free through per-word valid bits, no clearing pass.
// s_tready is low while an item is at work and until its result is taken.
`include "bitmap_first_fit_allocator_assert.svh"

module bitmap_first_fit_allocator
	import bffa_pkg::*;
#(
	parameter int MAP_BITS  = MAP_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [11:0] bit_index, [12] bit_value
	input  logic               s_tuser,   // [0] mode
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [11:0] free_index
	output logic               m_tuser,   // [0] found
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [VB_W-1:0]    cfg_data
);

	localparam int WC = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = (WC > 1) ? $clog2(WC) : 1;
	localparam int PW = $clog2(WORD_BITS);
	localparam int CW = VB_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WR,
		ST_SCAN,
		ST_OUT
	} state_t;

	state_t               state_q;
	logic [VB_W-1:0]      vb_q;
	logic [IDX_W-1:0]     start_q;
	logic [CW-1:0]        base_q;
	logic [VB_W-1:0]      limit_q;
	logic                 val_q;
	logic                 inr_q;
	logic                 m_tvalid_q;
	logic                 found_q;
	logic [IDX_W-1:0]     fidx_q;

	logic                 s_acc;
	logic [IDX_W-1:0]     in_idx;
	logic [VB_W-1:0]      lim;
	logic [CW-1:0]        in_base;
	logic [CW-1:0]        nxt;
	logic [CW-1:0]        rem;
	logic                 last;
	logic [AW-1:0]        raddr;
	logic [AW-1:0]        waddr;
	logic                 we;
	logic [WORD_BITS-1:0] wdata;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] lo_mask;
	logic [WORD_BITS-1:0] hi_mask;
	logic [WORD_BITS-1:0] free;
	logic [WORD_BITS-1:0] iso;
	logic [PW-1:0]        enc;
	logic [WORD_BITS-1:0] bmask;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign s_acc     = s_tvalid && s_tready;
	assign in_idx    = s_tdata[IDX_W-1:0];

	assign lim     = (32'(vb_q) > MAP_BITS) ? VB_W'(MAP_BITS) : vb_q;
	assign in_base = {{(CW-IDX_W){1'b0}}, in_idx} & ~CW'(WORD_BITS - 1);
	assign nxt     = base_q + CW'(WORD_BITS);
	assign last    = (nxt >= {1'b0, limit_q});
	assign rem     = {1'b0, limit_q} - base_q;

	always_comb begin
		unique case (state_q)
			ST_SCAN: raddr = AW'(nxt >> PW);
			default: raddr = AW'(in_base >> PW);
		endcase
	end

	assign waddr = AW'({{(CW-IDX_W){1'b0}}, start_q} >> PW);
	assign bmask = WORD_BITS'(1) << start_q[PW-1:0];
	assign wdata = val_q ? (rdata | bmask) : (rdata & ~bmask);
	assign we    = (state_q == ST_WR) && inr_q;

	bffa_map_ram #(
		.WORD_COUNT (WC),
		.WORD_BITS  (WORD_BITS),
		.AW         (AW)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	// lowest free bit of the current word within [start, limit)
	assign lo_mask = ({{(CW-IDX_W){1'b0}}, start_q} >= base_q) ?
		({WORD_BITS{1'b1}} << start_q[PW-1:0]) : {WORD_BITS{1'b1}};
	assign hi_mask = (rem >= CW'(WORD_BITS)) ?
		{WORD_BITS{1'b1}} : ~({WORD_BITS{1'b1}} << rem[PW-1:0]);
	assign free    = ~rdata & lo_mask & hi_mask;
	assign iso     = free & (~free + WORD_BITS'(1));

	always_comb begin
		enc = '0;
		for (int p = 0; p < WORD_BITS; p++) begin
			enc = enc | ({PW{iso[p]}} & PW'(p));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vb_q       <= VB_W'(VB_RESET);
			m_tvalid_q <= 1'b0;
			found_q    <= 1'b0;
			fidx_q     <= '0;
			start_q    <= '0;
			base_q     <= '0;
			limit_q    <= '0;
			val_q      <= 1'b0;
			inr_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				vb_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						start_q <= in_idx;
						base_q  <= in_base;
						limit_q <= lim;
						val_q   <= s_tdata[IDX_W];
						inr_q   <= (32'(in_idx) < MAP_BITS);
						priority if (s_tuser == MODE_WRITE) begin
							state_q <= ST_WR;
						end else if ({1'b0, in_idx} >= lim) begin
							found_q    <= 1'b0;
							fidx_q     <= '0;
							m_tvalid_q <= 1'b1;
							state_q    <= ST_OUT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_WR: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					priority if (|free) begin
						found_q    <= 1'b1;
						fidx_q     <= IDX_W'(base_q + CW'(enc));
						m_tvalid_q <= 1'b1;
						state_q    <= ST_OUT;
					end else if (last) begin
						found_q    <= 1'b0;
						fidx_q     <= '0;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_OUT;
					end else begin
						base_q <= nxt;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = {{(TDATA_W-IDX_W){1'b0}}, fidx_q};

	`BFFA_ASSERT_NOW(a_no_overlap, 1'b1, !(s_tready && m_tvalid), "ready while result pending")
	`BFFA_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser, m_tdata == '0, "miss with nonzero index")
	`BFFA_ASSERT_NOW(a_hit_range, m_tvalid && m_tuser, (fidx_q >= start_q) && ({1'b0, fidx_q} < limit_q), "hit outside search range")
	`BFFA_ASSERT_NEXT(a_wr_silent, s_acc && (s_tuser == MODE_WRITE), !m_tvalid && (state_q == ST_WR), "write item gave a result")

endmodule
